[src/ssd_pkg.sv]
`timescale 1ns / 1ps
package ssd_pkg;

	localparam int DIGITS = 4;

	typedef logic [7:0] seg_t;
	typedef logic [3:0] bcd_t;
	typedef logic [2:0] fmt_mode_t;

	localparam fmt_mode_t FMT_HEX          = 3'd0;
	localparam fmt_mode_t FMT_UNS_ZEROS    = 3'd1;
	localparam fmt_mode_t FMT_SGN_ZEROS    = 3'd2;
	localparam fmt_mode_t FMT_UNS_BLANKED  = 3'd3;
	localparam fmt_mode_t FMT_SGN_BLANKED  = 3'd4;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	localparam logic CFG_ENABLE = 1'b0;
	localparam logic CFG_FORMAT = 1'b1;

	localparam seg_t SEG_BLANK = 8'h00;
	localparam seg_t SEG_MINUS = 8'h40;
	localparam seg_t SEG_R     = 8'h50;
	localparam bcd_t HEX_E     = 4'hE;

	typedef struct packed {
		logic func;
		logic commit;
		logic ok;
		seg_t [DIGITS-1:0] digits;
	} fmt_res_t;

	function automatic seg_t glyph(input bcd_t d);
		seg_t s;
		case (d)
			4'h0: s = 8'h3F;
			4'h1: s = 8'h06;
			4'h2: s = 8'h5B;
			4'h3: s = 8'h4F;
			4'h4: s = 8'h66;
			4'h5: s = 8'h6D;
			4'h6: s = 8'h7D;
			4'h7: s = 8'h07;
			4'h8: s = 8'h7F;
			4'h9: s = 8'h6F;
			4'hA: s = 8'h77;
			4'hB: s = 8'h7C;
			4'hC: s = 8'h39;
			4'hD: s = 8'h5E;
			4'hE: s = 8'h79;
			4'hF: s = 8'h71;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] popcount8(input seg_t s);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 8; i++) begin
			c = c + {3'd0, s[i]};
		end
		return c;
	endfunction

endpackage

[src/ssd_if.sv]
`timescale 1ns / 1ps
interface ssd_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] number;
	logic        commit;

	modport source (output valid, output func, output number, output commit, input ready);
	modport sink (input valid, input func, input number, input commit, output ready);
endinterface

interface ssd_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] digit_select_n;
	logic [7:0] segment_lines_n;
	logic       format_ok;

	modport source (output valid, output digit_select_n, output segment_lines_n,
		output format_ok, input ready);
	modport sink (input valid, input digit_select_n, input segment_lines_n,
		input format_ok, output ready);
endinterface

[src/ssd_fmt.sv]
`timescale 1ns / 1ps
module ssd_fmt import ssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic        func,
	input  logic [15:0] number,
	input  logic        commit,
	input  fmt_mode_t   format_mode,
	output logic        res_valid,
	output fmt_res_t    res
);

	logic        valid_s1, valid_s2, valid_s3;
	logic        func_s1, func_s2, func_s3;
	logic        commit_s1, commit_s2, commit_s3;
	logic [15:0] number_s1, number_s2, number_s3;
	logic        err_s2, err_s3;
	logic        neg_s2, neg_s3;
	bcd_t        th_s2, th_s3;
	logic [9:0]  rem_s2;
	bcd_t        hu_s3;
	logic [6:0]  rem_s3;

	logic        is_signed, neg, err;
	logic [15:0] mag;
	bcd_t        th;
	logic [13:0] rem_th;
	bcd_t        hu;
	logic [9:0]  rem_hu;
	bcd_t        te, on;
	logic [6:0]  rem_te;
	logic        blank;

	// Sign, range check and the thousands digit.
	always_comb begin
		is_signed = (format_mode == FMT_SGN_ZEROS) || (format_mode == FMT_SGN_BLANKED);
		neg = is_signed && number_s1[15];
		mag = neg ? (16'd0 - number_s1) : number_s1;
		if ((format_mode == FMT_UNS_ZEROS) || (format_mode == FMT_UNS_BLANKED) || is_signed) begin
			err = neg ? (mag > 16'd999) : (number_s1 > 16'd9999);
		end else begin
			err = 1'b0;
		end
		th = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (mag[13:0] >= 14'(k * 1000)) begin
				th = 4'(k);
			end
		end
		rem_th = mag[13:0] - 14'({10'd0, th} * 14'd1000);
	end

	// Hundreds digit.
	always_comb begin
		hu = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (rem_s2 >= 10'(k * 100)) begin
				hu = 4'(k);
			end
		end
		rem_hu = rem_s2 - 10'({6'd0, hu} * 10'd100);
	end

	// Tens and ones, then the segment bytes.
	always_comb begin
		te = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (rem_s3 >= 7'(k * 10)) begin
				te = 4'(k);
			end
		end
		rem_te = rem_s3 - 7'({3'd0, te} * 7'd10);
		on = rem_te[3:0];
		blank = (format_mode == FMT_UNS_BLANKED) || (format_mode == FMT_SGN_BLANKED);

		res.func = func_s3;
		res.commit = commit_s3;
		res.ok = !(func_s3 && err_s3);
		res.digits = '0;
		if (err_s3) begin
			res.digits[3] = SEG_BLANK;
			res.digits[2] = glyph(HEX_E);
			res.digits[1] = SEG_R;
			res.digits[0] = SEG_R;
		end else if ((format_mode == FMT_UNS_ZEROS) || (format_mode == FMT_UNS_BLANKED)
				|| (format_mode == FMT_SGN_ZEROS) || (format_mode == FMT_SGN_BLANKED)) begin
			res.digits[3] = (blank && th_s3 == 4'd0) ? SEG_BLANK : glyph(th_s3);
			res.digits[2] = (blank && th_s3 == 4'd0 && hu_s3 == 4'd0) ? SEG_BLANK
				: glyph(hu_s3);
			res.digits[1] = (blank && th_s3 == 4'd0 && hu_s3 == 4'd0 && te == 4'd0)
				? SEG_BLANK : glyph(te);
			res.digits[0] = glyph(on);
			if (neg_s3) begin
				if (!blank || hu_s3 != 4'd0) begin
					res.digits[3] = SEG_MINUS;
				end else if (te != 4'd0) begin
					res.digits[2] = SEG_MINUS;
				end else begin
					res.digits[1] = SEG_MINUS;
				end
			end
		end else begin
			for (int i = 0; i < DIGITS; i++) begin
				res.digits[i] = glyph(number_s3[4*i +: 4]);
			end
		end
	end

	assign res_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1   <= func;
			number_s1 <= number;
			commit_s1 <= commit;

			func_s2   <= func_s1;
			number_s2 <= number_s1;
			commit_s2 <= commit_s1;
			err_s2    <= err;
			neg_s2    <= neg;
			th_s2     <= th;
			rem_s2    <= rem_th[9:0];

			func_s3   <= func_s2;
			number_s3 <= number_s2;
			commit_s3 <= commit_s2;
			err_s3    <= err_s2;
			neg_s3    <= neg_s2;
			th_s3     <= th_s2;
			hu_s3     <= hu;
			rem_s3    <= rem_hu[6:0];
		end
	end

endmodule

[src/seven_segment_display_controller.sv]
`timescale 1ns / 1ps
// Each accepted item passes the formatting stages and then the output register.
// Throughput: one item per cycle; three formatting stages feed the scan state and
// the output register, and all of them advance together whenever the output is free.
// Reset: the display is enabled in hex mode, all digits are blank and dark, and an
// update is pending so the first wrap of the scan adopts the pending digits.
module seven_segment_display_controller import ssd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [2:0] cfg_data,
	ssd_in_if.sink     item_in,
	ssd_out_if.source  result_out
);

	logic       en;
	logic       res_valid;
	fmt_res_t   res;

	logic       display_enable_q;
	fmt_mode_t  format_mode_q;
	logic [1:0] scan_digit_q;
	logic [3:0] scan_phase_q;
	logic [3:0] on_time_q;
	seg_t       shown_q [DIGITS];
	seg_t       pending_q [DIGITS];
	logic       update_pending_q;
	logic [3:0] digit_lines_q;
	seg_t       segment_lines_q;
	logic       format_ok_q;
	logic       out_valid_q;

	logic       step0;
	logic       wrap;
	logic       copy;
	logic [1:0] next_digit;
	seg_t       sel_seg;
	logic [3:0] next_on;
	logic [3:0] next_lines;

	assign en = !out_valid_q || result_out.ready;
	assign item_in.ready = en;

	assign result_out.valid = out_valid_q;
	assign result_out.digit_select_n = digit_lines_q;
	assign result_out.segment_lines_n = segment_lines_q;
	assign result_out.format_ok = format_ok_q;

	ssd_fmt u_fmt (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (item_in.valid),
		.func        (item_in.func),
		.number      (item_in.number),
		.commit      (item_in.commit),
		.format_mode (format_mode_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_comb begin
		step0 = (scan_phase_q == 4'd0);
		wrap = (scan_digit_q == 2'(DIGITS - 1));
		next_digit = wrap ? 2'd0 : scan_digit_q + 2'd1;
		copy = step0 && wrap && update_pending_q;
		sel_seg = copy ? pending_q[next_digit] : shown_q[next_digit];
		next_on = step0 ? popcount8(sel_seg) : on_time_q;
		next_lines = step0 ? ~(4'b0001 << next_digit) : digit_lines_q;
		if (next_on == scan_phase_q) begin
			next_lines = 4'hF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_enable_q <= 1'b1;
			format_mode_q    <= FMT_HEX;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE: display_enable_q <= cfg_data[0];
				CFG_FORMAT: format_mode_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_digit_q     <= 2'd0;
			scan_phase_q     <= 4'd0;
			on_time_q        <= 4'd0;
			update_pending_q <= 1'b1;
			digit_lines_q    <= 4'hF;
			segment_lines_q  <= 8'hFF;
			format_ok_q      <= 1'b1;
			out_valid_q      <= 1'b0;
			for (int i = 0; i < DIGITS; i++) begin
				shown_q[i]   <= SEG_BLANK;
				pending_q[i] <= SEG_BLANK;
			end
		end else if (en) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				format_ok_q <= res.ok;
				if (res.func == FUNC_WRITE) begin
					for (int i = 0; i < DIGITS; i++) begin
						pending_q[i] <= res.digits[i];
					end
					if (res.commit) begin
						update_pending_q <= 1'b1;
					end
				end else if (!display_enable_q) begin
					digit_lines_q <= 4'hF;
				end else begin
					if (step0) begin
						scan_digit_q    <= next_digit;
						segment_lines_q <= ~sel_seg;
						on_time_q       <= next_on;
					end
					if (copy) begin
						for (int i = 0; i < DIGITS; i++) begin
							shown_q[i] <= pending_q[i];
						end
						update_pending_q <= 1'b0;
					end
					digit_lines_q <= next_lines;
					scan_phase_q  <= (scan_phase_q >= 4'd8) ? 4'd0 : scan_phase_q + 4'd1;
				end
			end
		end
	end

endmodule
